@@ rtl/core/image_channel_histogram_stats_assert.svh @@
// Assertion macros used by the histogram statistics checker.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef IMAGE_CHANNEL_HISTOGRAM_STATS_ASSERT_SVH
`define IMAGE_CHANNEL_HISTOGRAM_STATS_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ICHS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram statistics assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ICHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram statistics assertion failed");

`endif

@@ rtl/core/ichs_pkg.sv @@
// Shared types, constants and helper functions of the image histogram statistics block.
// No dependencies.
package ichs_pkg;

  localparam int LEVELS   = 256;
  localparam int IDX_W    = 8;
  localparam int BIN_W    = 25;
  localparam int NUM_CH   = 4;
  localparam int NUM_HIST = 5;
  localparam int TOT_W    = 33;
  localparam int S1_W     = 41;
  localparam int S2_W     = 48;
  localparam int DIV_W    = 64;
  localparam int SUM_W    = 18;

  localparam logic [BIN_W-1:0] MAX_PIXELS = 25'd16777216;
  localparam logic [2:0] AVG_CHANNEL = 3'd4;

  localparam logic [2:0] FMT_RGBA = 3'd0;
  localparam logic [2:0] FMT_BGRA = 3'd1;
  localparam logic [2:0] FMT_ARGB = 3'd2;
  localparam logic [2:0] FMT_ABGR = 3'd3;
  localparam logic [2:0] FMT_RGB  = 3'd4;
  localparam logic [2:0] FMT_BGR  = 3'd5;
  localparam logic [2:0] FMT_MONO = 3'd6;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [2:0]       channel;
    logic [15:0]      mean_value;
    logic [15:0]      deviation;
    logic [15:0]      median_value;
    logic [BIN_W-1:0] peak_count;
    logic             last_result;
  } stat_out_t;

  typedef logic [NUM_CH-1:0][7:0] rgba_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_MEDIAN,
    ST_DIV_MEAN,
    ST_DIV_E2,
    ST_SQUARE,
    ST_SQRT,
    ST_EMIT,
    ST_DIV_AVG,
    ST_EMIT_AVG
  } state_t;

  // Element 0 is R, 1 is G, 2 is B, 3 is A.
  function automatic rgba_t map_pixel(logic [2:0] fmt, pixel_in_t p);
    rgba_t v;
    v = '0;
    unique case (fmt)
      FMT_RGBA: begin
        v[0] = p.byte0; v[1] = p.byte1; v[2] = p.byte2; v[3] = p.byte3;
      end
      FMT_BGRA: begin
        v[2] = p.byte0; v[1] = p.byte1; v[0] = p.byte2; v[3] = p.byte3;
      end
      FMT_ARGB: begin
        v[3] = p.byte0; v[0] = p.byte1; v[1] = p.byte2; v[2] = p.byte3;
      end
      FMT_ABGR: begin
        v[3] = p.byte0; v[2] = p.byte1; v[1] = p.byte2; v[0] = p.byte3;
      end
      FMT_RGB: begin
        v[0] = p.byte0; v[1] = p.byte1; v[2] = p.byte2;
      end
      FMT_BGR: begin
        v[2] = p.byte0; v[1] = p.byte1; v[0] = p.byte2;
      end
      FMT_MONO: begin
        v[0] = p.byte0;
      end
      default: begin
        v = '0;
      end
    endcase
    return v;
  endfunction

  // (R+G+B)/3 as a multiply by 683/2048, exact for sums below 2048.
  function automatic logic [7:0] luma_of(rgba_t v);
    logic [9:0]  s;
    logic [19:0] prod;
    s    = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]};
    prod = {10'b0, s} * 20'd683;
    return prod[18:11];
  endfunction

endpackage

@@ rtl/core/ichs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ichs_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/image_channel_histogram_stats.sv @@
// Top level of the image channel histogram statistics block.
// Depends on ichs_pkg and ichs_ram.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  in      | in_valid / in_ready   | in_data  (pixel_in_t)
//  out     | out_valid / out_ready | out_data (stat_out_t)
//  cfg     | cfg_valid / cfg_ready | cfg_data (pixel format)
//
// A pixel's five bins are read, then written back, before the next pixel is taken.
// After reset a clearing pass over all bins runs before the first pixel transfer.
// A last pixel starts a frame pass: a sum sweep, a median sweep that also
// clears the bins, a division for each of 8 quotients, a square root per
// channel and the averages over the three color channels.
// Output stalls hold the sequencer at the emitting step; cfg_ready is always high.
module image_channel_histogram_stats
  import ichs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output stat_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  state_t state, state_next;
  logic [2:0] fmt;
  logic [8:0] sweep;

  logic [NUM_HIST-1:0]            ram_we;
  logic [NUM_HIST-1:0][IDX_W-1:0] ram_waddr, ram_raddr;
  logic [NUM_HIST-1:0][BIN_W-1:0] ram_wdata, ram_rdata;

  logic [NUM_HIST-1:0][IDX_W-1:0] pix_idx, upd_idx;
  logic                           upd_last;
  logic [NUM_HIST-1:0][BIN_W-1:0] bin_new;
  logic [NUM_HIST-1:0][BIN_W-1:0] peak;
  rgba_t                          pix_vals;

  logic                         v1, v2;
  logic [IDX_W-1:0]             idx1;
  logic [15:0]                  sq1;
  logic [NUM_CH-1:0][BIN_W-1:0] h2;
  logic [NUM_CH-1:0][32:0]      p1;
  logic [NUM_CH-1:0][40:0]      p2;
  logic [NUM_CH-1:0][TOT_W-1:0] tot;
  logic [NUM_CH-1:0][S1_W-1:0]  s1;
  logic [NUM_CH-1:0][S2_W-1:0]  s2;

  logic [NUM_CH-1:0][TOT_W-1:0] acc, acc_next;
  logic [NUM_CH-1:0]            found;
  logic [NUM_CH-1:0][IDX_W-1:0] med;

  logic [DIV_W-1:0] div_num, div_quot, quot_next;
  logic [TOT_W-1:0] div_den, div_rem, rem_next;
  logic [TOT_W:0]   rem_shift;
  logic             div_ge, div_done;
  logic [5:0]       div_cnt;

  logic [1:0]  chan, chan_load;
  logic [15:0] mean_r, root, trial;
  logic [31:0] e2, m2, var_r, trial_sq;
  logic [4:0]  sq_cnt;
  logic [3:0]  bit_pos;
  logic [2:0][SUM_W-1:0] sums;
  logic [2:0][15:0]      avg;

  logic in_xfer, out_free;

  function automatic logic [TOT_W-1:0] den_of(logic [TOT_W-1:0] t);
    return (t == '0) ? TOT_W'(1) : t;
  endfunction

  // Division by three as a multiply by ceil(2^19/3), exact below 2^19.
  function automatic logic [15:0] third_of(logic [SUM_W-1:0] x);
    logic [35:0] prod;
    prod = 36'(x) * 36'd174763;
    return prod[34:19];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign pix_vals = map_pixel(fmt, in_data);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pix_idx[c] = pix_vals[c];
    end
    pix_idx[NUM_HIST-1] = luma_of(pix_vals);
  end

  // Bin memories: four color channels and the luminance.
  for (genvar h = 0; h < NUM_HIST; h++) begin : g_bins
    ichs_ram #(.WIDTH(BIN_W), .DEPTH(LEVELS)) u_ram (
      .clk   (clk),
      .we    (ram_we[h]),
      .waddr (ram_waddr[h]),
      .wdata (ram_wdata[h]),
      .raddr (ram_raddr[h]),
      .rdata (ram_rdata[h])
    );
  end

  always_comb begin
    for (int h = 0; h < NUM_HIST; h++) begin
      bin_new[h]   = (ram_rdata[h] < MAX_PIXELS) ? ram_rdata[h] + BIN_W'(1) : ram_rdata[h];
      ram_raddr[h] = (state == ST_IDLE) ? pix_idx[h] : sweep[IDX_W-1:0];
    end
  end

  // Divider step: one quotient bit per cycle.
  assign rem_shift = {div_rem, div_num[DIV_W-1]};
  assign div_ge    = rem_shift >= {1'b0, div_den};
  assign rem_next  = div_ge ? TOT_W'(rem_shift - {1'b0, div_den}) : TOT_W'(rem_shift);
  assign quot_next = {div_quot[DIV_W-2:0], div_ge};
  assign div_done  = (div_cnt == 6'd63);

  assign bit_pos  = 4'(5'd16 - sq_cnt);
  assign trial    = root | (16'd1 << bit_pos);
  assign trial_sq = 32'(trial) * 32'(trial);

  assign chan_load = (state == ST_MEDIAN) ? 2'd0 : chan + 2'd1;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_next[c] = acc[c] + TOT_W'(ram_rdata[c]);
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = '0;
    ram_waddr  = upd_idx;
    ram_wdata  = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = '1;
        for (int h = 0; h < NUM_HIST; h++) begin
          ram_waddr[h] = sweep[IDX_W-1:0];
        end
        if (sweep[IDX_W-1:0] == 8'd255) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ram_we     = '1;
        ram_wdata  = bin_new;
        state_next = upd_last ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (sweep[8] && !v1 && !v2) begin
          state_next = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        // Bins are cleared right after they are read for the median.
        ram_we = {NUM_HIST{v1}};
        for (int h = 0; h < NUM_HIST; h++) begin
          ram_waddr[h] = idx1;
        end
        if (sweep[8] && !v1) begin
          state_next = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          state_next = ST_DIV_E2;
        end
      end
      ST_DIV_E2: begin
        if (div_done) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt == 5'd16) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (chan == 2'd3) ? ST_DIV_AVG : ST_DIV_MEAN;
        end
      end
      ST_DIV_AVG: begin
        state_next = ST_EMIT_AVG;
      end
      ST_EMIT_AVG: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      fmt       <= FMT_RGBA;
      sweep     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      peak      <= '0;
    end else begin
      state <= state_next;
      v1    <= (state == ST_SUM || state == ST_MEDIAN) && !sweep[8];
      v2    <= (state == ST_SUM) && v1;
      if (cfg_valid && cfg_ready) begin
        fmt <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + 9'd1;
        end
        ST_UPDATE: begin
          sweep <= '0;
          for (int h = 0; h < NUM_HIST; h++) begin
            if (peak[h] < bin_new[h]) begin
              peak[h] <= bin_new[h];
            end
          end
        end
        ST_SUM: begin
          if (state_next == ST_MEDIAN) begin
            sweep <= '0;
          end else if (!sweep[8]) begin
            sweep <= sweep + 9'd1;
          end
        end
        ST_MEDIAN: begin
          if (!sweep[8]) begin
            sweep <= sweep + 9'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        ST_EMIT_AVG: begin
          if (out_free) begin
            out_valid <= 1'b1;
            peak      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    idx1 <= sweep[IDX_W-1:0];
    sq1  <= 16'(sweep[IDX_W-1:0]) * 16'(sweep[IDX_W-1:0]);
    for (int c = 0; c < NUM_CH; c++) begin
      h2[c] <= ram_rdata[c];
      p1[c] <= 33'(idx1) * 33'(ram_rdata[c]);
      p2[c] <= 41'(sq1) * 41'(ram_rdata[c]);
    end
    if (in_xfer) begin
      upd_idx  <= pix_idx;
      upd_last <= in_data.last_pixel;
    end
    if (state == ST_DIV_MEAN || state == ST_DIV_E2) begin
      div_rem  <= rem_next;
      div_num  <= {div_num[DIV_W-2:0], 1'b0};
      div_quot <= quot_next;
      div_cnt  <= div_cnt + 6'd1;
    end
    unique case (state)
      ST_UPDATE: begin
        tot <= '0;
        s1  <= '0;
        s2  <= '0;
      end
      ST_SUM: begin
        if (v2) begin
          for (int c = 0; c < NUM_CH; c++) begin
            tot[c] <= tot[c] + TOT_W'(h2[c]);
            s1[c]  <= s1[c] + S1_W'(p1[c]);
            s2[c]  <= s2[c] + S2_W'(p2[c]);
          end
        end
        acc   <= '0;
        found <= '0;
        med   <= '0;
      end
      ST_MEDIAN: begin
        if (v1) begin
          for (int c = 0; c < NUM_CH; c++) begin
            acc[c] <= acc_next[c];
            if (!found[c] && acc_next[c] >= (tot[c] >> 1)) begin
              found[c] <= 1'b1;
              med[c]   <= idx1;
            end
          end
        end
        sums <= '0;
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mean_r  <= quot_next[15:0];
          div_num <= {s2[chan], 16'b0};
          div_rem <= '0;
        end
      end
      ST_DIV_E2: begin
        if (div_done) begin
          e2 <= quot_next[31:0];
        end
      end
      ST_SQUARE: begin
        m2     <= 32'(mean_r) * 32'(mean_r);
        sq_cnt <= '0;
      end
      ST_SQRT: begin
        if (sq_cnt == 5'd0) begin
          var_r <= (e2 > m2) ? e2 - m2 : 32'd0;
          root  <= '0;
        end else if (trial_sq <= var_r) begin
          root <= trial;
        end
        sq_cnt <= sq_cnt + 5'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data.channel      <= {1'b0, chan};
          out_data.mean_value   <= mean_r;
          out_data.deviation    <= root;
          out_data.median_value <= {med[chan], 8'b0};
          out_data.peak_count   <= peak[chan];
          out_data.last_result  <= 1'b0;
          if (chan != 2'd3) begin
            sums[0] <= sums[0] + SUM_W'(mean_r);
            sums[1] <= sums[1] + SUM_W'(root);
            sums[2] <= sums[2] + SUM_W'({med[chan], 8'b0});
          end
        end
      end
      ST_DIV_AVG: begin
        for (int k = 0; k < 3; k++) begin
          avg[k] <= third_of(sums[k]);
        end
      end
      ST_EMIT_AVG: begin
        if (out_free) begin
          out_data.channel      <= AVG_CHANNEL;
          out_data.mean_value   <= avg[0];
          out_data.deviation    <= avg[1];
          out_data.median_value <= avg[2];
          out_data.peak_count   <= peak[NUM_HIST-1];
          out_data.last_result  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Load the mean division whenever a channel's computation begins.
    if (state_next == ST_DIV_MEAN && state != ST_DIV_MEAN) begin
      chan    <= chan_load;
      div_num <= DIV_W'({s1[chan_load], 8'b0});
      div_den <= den_of(tot[chan_load]);
      div_rem <= '0;
      div_cnt <= '0;
    end
  end

endmodule

@@ rtl/core/ichs_checker.sv @@
// Port-level checker for the image histogram statistics block, bound to the top level.
// Depends on ichs_pkg and image_channel_histogram_stats_assert.svh.
`include "image_channel_histogram_stats_assert.svh"

module ichs_checker
  import ichs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input stat_out_t out_data
);

  // A pending result holds until its transfer.
  `ICHS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // Only the closing result carries the averaged channel.
  `ICHS_ASSERT_SAME(a_last_is_avg, clk, rst, out_valid, out_data.last_result == (out_data.channel == AVG_CHANNEL))

  // While a frame's results are still being produced, no pixel is taken.
  `ICHS_ASSERT_SAME(a_no_pixel_mid_frame, clk, rst, out_valid && !out_data.last_result, !in_ready)

  // Channel codes stay in range.
  `ICHS_ASSERT_SAME(a_channel_range, clk, rst, out_valid, out_data.channel <= AVG_CHANNEL)

endmodule

bind image_channel_histogram_stats ichs_checker u_ichs_checker (.*);
